// File: rtl/core/spg_pkg.sv
// shared constants, types and helpers for the serpentine scan point generator
package spg_pkg;

    // grid geometry
    localparam int PACK_COLUMNS = 8;
    localparam int PACK_ROWS    = 8;
    localparam int CELL_COLUMNS = 8;
    localparam int CELL_ROWS    = 8;

    localparam int PACK_TOTAL = PACK_COLUMNS * PACK_ROWS;

    // field and register widths
    localparam int COORD_W   = 20;
    localparam int MARGIN_W  = 16;
    localparam int LEN_W     = 14;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int KIND_W    = 2;

    localparam int PX_W   = (PACK_COLUMNS > 1) ? $clog2(PACK_COLUMNS) : 1;
    localparam int PY_W   = (PACK_ROWS > 1) ? $clog2(PACK_ROWS) : 1;
    localparam int SLOT_W = PX_W + PY_W;
    localparam int IDX_W  = (PACK_TOTAL > 1) ? $clog2(PACK_TOTAL) : 1;
    localparam int CNT_W  = $clog2(PACK_TOTAL + 1);

    localparam int CC_W = $clog2(CELL_COLUMNS);
    localparam int CR_W = $clog2(CELL_ROWS);
    localparam int K_W  = (CC_W > CR_W) ? CC_W : CR_W;

    // half-up rounding: (2*len*k + div) / (2*div), divided by a reciprocal multiply
    localparam int DEN_X   = 2 * (CELL_COLUMNS - 1);
    localparam int DEN_Y   = 2 * (CELL_ROWS - 1);
    localparam int DEN_MAX = (DEN_X > DEN_Y) ? DEN_X : DEN_Y;
    localparam int NUM_W   = LEN_W + K_W + 1;
    localparam int RECIP_SH = NUM_W + $clog2(DEN_MAX);
    localparam int RECIP_W  = RECIP_SH;
    localparam int RECIP_X  = ((1 << RECIP_SH) + DEN_X - 1) / DEN_X;
    localparam int RECIP_Y  = ((1 << RECIP_SH) + DEN_Y - 1) / DEN_Y;

    // multiplier operand b carries a pack index, twice a cell index or a reciprocal
    localparam int MB_P   = (PX_W > PY_W) ? PX_W : PY_W;
    localparam int MB_Q   = (MB_P > K_W + 1) ? MB_P : K_W + 1;
    localparam int MB_W   = (MB_Q > RECIP_W) ? MB_Q : RECIP_W;
    localparam int MA_W   = (LEN_W + 1 > NUM_W) ? LEN_W + 1 : NUM_W;
    localparam int PROD_W = MA_W + MB_W;

    typedef enum logic [1:0] {
        PH_CHECK  = 2'd0,
        PH_TARGET = 2'd1,
        PH_DONE   = 2'd2
    } phase_t;

    localparam logic [KIND_W-1:0] KIND_RESTART = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REPORT  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TARGET  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_MARGIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM_MARGIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PACK_WIDTH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PACK_HEIGHT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_X         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_Y         = 3'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_ORG,
        S_NUM,
        S_DIV,
        S_ADD,
        S_EMIT
    } seq_state_t;

    typedef enum logic [1:0] {
        ACT_RESTART,
        ACT_REPORT,
        ACT_TARGET,
        ACT_WRONG
    } act_t;

    // pack column for a serpentine scan position (row from the top, step within row)
    function automatic logic [PX_W-1:0] pack_x(input logic [PY_W-1:0] scan_row,
                                              input logic [PX_W-1:0] scan_col);
        logic [PX_W-1:0] px;
        if (scan_row[0])
            px = scan_col;
        else
            px = PX_W'(PACK_COLUMNS - 1) - scan_col;
        return px;
    endfunction

    function automatic logic [PY_W-1:0] pack_y(input logic [PY_W-1:0] scan_row);
        logic [PY_W-1:0] py;
        py = PY_W'(PACK_ROWS - 1) - scan_row;
        return py;
    endfunction

endpackage

// File: rtl/core/serpentine_grid_scan_point_generator_core.sv
// serpentine grid scan point generator: check phase, passed-pack stack, target phase
//
//  channel  | signals                                         | direction
//  ---------+-------------------------------------------------+----------
//  item     | item_valid, item_stall, kind, check_passed      | in
//  result   | result_valid, result_stall, phase, point_valid, | out
//           | point_x, point_y, pack_done, wrong_phase        |
//  config   | cfg_write, cfg_index, cfg_data                  | in
//
// a check point runs origin and add per axis, a wrong-phase item or a final report goes
// to emit; a cell point reads the stack, then the shared multiply-add unit per axis forms
// the origin, the rounding numerator and a reciprocal multiply that divides it.
// reset clears the scan state, the sequencer and the configuration registers; the pack stack needs no clearing.
// item_stall is high from the transfer until the result sits in the output register;
// a stalled result holds while the sequencer already takes the next item.
module serpentine_grid_scan_point_generator_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  logic [spg_pkg::KIND_W-1:0]      kind,
    input  logic                            check_passed,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic [1:0]                      phase,
    output logic                            point_valid,
    output logic [spg_pkg::COORD_W-1:0]     point_x,
    output logic [spg_pkg::COORD_W-1:0]     point_y,
    output logic                            pack_done,
    output logic                            wrong_phase,
    input  logic                            cfg_write,
    input  logic [spg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [spg_pkg::CFG_W-1:0]       cfg_data
);
    import spg_pkg::*;

    // configuration
    logic [MARGIN_W-1:0] left_margin_reg, bottom_margin_reg;
    logic [LEN_W-1:0]    pack_width_reg, pack_height_reg, gap_x_reg, gap_y_reg;

    // scan state
    phase_t              phase_reg, phase_next;
    logic [PX_W-1:0]     chk_col_reg, chk_col_next;
    logic [PY_W-1:0]     chk_row_reg, chk_row_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CC_W-1:0]     cell_col_reg, cell_col_next;
    logic [CR_W-1:0]     cell_row_reg, cell_row_next;

    // sequencer and work registers
    seq_state_t          state_reg, state_next;
    logic                axis_reg, axis_next;
    logic                cell_mode_reg, cell_mode_next;
    logic                pv_reg, pv_next;
    logic                wrong_reg, wrong_next;
    logic                done_reg, done_next;
    logic [PX_W-1:0]     px_reg, px_next;
    logic [PY_W-1:0]     py_reg, py_next;
    logic [K_W-1:0]      kx_reg, kx_next;
    logic [K_W-1:0]      ky_reg, ky_next;
    logic [COORD_W-1:0]  acc_x_reg, acc_x_next;
    logic [COORD_W-1:0]  acc_y_reg, acc_y_next;
    logic [NUM_W-1:0]    num_reg, num_next;
    logic [LEN_W-1:0]    quo_reg, quo_next;

    // output register
    logic                result_valid_reg, result_valid_next;
    logic [1:0]          phase_out_reg;
    logic                point_valid_reg, pack_done_reg, wrong_phase_reg;
    logic [COORD_W-1:0]  point_x_reg, point_y_reg;

    // pack stack
    logic [SLOT_W-1:0]   stack_mem [PACK_TOTAL];
    logic [SLOT_W-1:0]   rd_slot_reg;
    logic                push, pop;
    logic [CNT_W-1:0]    cnt_dec;
    logic [IDX_W-1:0]    wr_addr, rd_addr;
    logic [SLOT_W-1:0]   cur_slot;

    // shared multiply-add unit
    logic [MA_W-1:0]     mac_a;
    logic [MB_W-1:0]     mac_b;
    logic [COORD_W-1:0]  mac_c;
    logic [PROD_W-1:0]   mac_prod;
    logic [COORD_W-1:0]  mac_res;

    logic                item_accept, emit_fire;
    act_t                act;
    logic                chk_col_last, chk_last;
    logic [PX_W-1:0]     nxt_col;
    logic [PY_W-1:0]     nxt_row;
    logic                cell_col_last, cell_row_last;
    logic [LEN_W-1:0]    len_sel;
    logic [LEN_W-1:0]    offset;

    assign item_stall  = (state_reg != S_IDLE);
    assign item_accept = item_valid && !item_stall;
    assign emit_fire   = (state_reg == S_EMIT) && (!result_valid_reg || !result_stall);

    assign result_valid = result_valid_reg;
    assign phase        = phase_out_reg;
    assign point_valid  = point_valid_reg;
    assign point_x      = point_x_reg;
    assign point_y      = point_y_reg;
    assign pack_done    = pack_done_reg;
    assign wrong_phase  = wrong_phase_reg;

    // request decode against the current phase
    always_comb
    begin
        priority if (kind == KIND_RESTART)
            act = ACT_RESTART;
        else if (kind == KIND_REPORT && phase_reg == PH_CHECK)
            act = ACT_REPORT;
        else if (kind == KIND_TARGET && phase_reg == PH_TARGET && count_reg != '0)
            act = ACT_TARGET;
        else
            act = ACT_WRONG;
    end

    assign chk_col_last  = (chk_col_reg == PX_W'(PACK_COLUMNS - 1));
    assign chk_last      = chk_col_last && (chk_row_reg == PY_W'(PACK_ROWS - 1));
    assign nxt_col       = chk_col_last ? '0 : chk_col_reg + PX_W'(1);
    assign nxt_row       = chk_col_last ? chk_row_reg + PY_W'(1) : chk_row_reg;
    assign cell_col_last = (cell_col_reg == CC_W'(CELL_COLUMNS - 1));
    assign cell_row_last = (cell_row_reg == CR_W'(CELL_ROWS - 1));

    assign cur_slot = {pack_y(chk_row_reg), pack_x(chk_row_reg, chk_col_reg)};
    assign cnt_dec  = count_reg - CNT_W'(1);
    assign wr_addr  = count_reg[IDX_W-1:0];
    assign rd_addr  = cnt_dec[IDX_W-1:0];

    assign len_sel = axis_reg ? pack_height_reg : pack_width_reg;
    assign offset  = cell_mode_reg ? quo_reg : (len_sel >> 1);

    always_comb
    begin
        mac_a = '0;
        mac_b = '0;
        mac_c = '0;
        unique case (state_reg)
            S_ORG:
            begin
                if (axis_reg)
                begin
                    mac_a = MA_W'(pack_height_reg) + MA_W'(gap_y_reg);
                    mac_b = MB_W'(py_reg);
                    mac_c = COORD_W'(bottom_margin_reg);
                end
                else
                begin
                    mac_a = MA_W'(pack_width_reg) + MA_W'(gap_x_reg);
                    mac_b = MB_W'(px_reg);
                    mac_c = COORD_W'(left_margin_reg);
                end
            end
            S_NUM:
            begin
                mac_a = MA_W'(len_sel);
                mac_b = MB_W'({(axis_reg ? ky_reg : kx_reg), 1'b0});
                mac_c = axis_reg ? COORD_W'(CELL_ROWS - 1) : COORD_W'(CELL_COLUMNS - 1);
            end
            S_DIV:
            begin
                // exact floor division of the numerator by twice the cell span
                mac_a = MA_W'(num_reg);
                mac_b = axis_reg ? MB_W'(RECIP_Y) : MB_W'(RECIP_X);
            end
            S_ADD:
            begin
                mac_a = MA_W'(offset);
                mac_b = MB_W'(1);
                mac_c = axis_reg ? acc_y_reg : acc_x_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign mac_prod = PROD_W'(mac_a) * PROD_W'(mac_b);
    assign mac_res  = mac_prod[COORD_W-1:0] + mac_c;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_accept)
                begin
                    unique case (act)
                        ACT_RESTART: state_next = S_ORG;
                        ACT_REPORT:  state_next = chk_last ? S_EMIT : S_ORG;
                        ACT_TARGET:  state_next = S_READ;
                        ACT_WRONG:   state_next = S_EMIT;
                        default:     state_next = S_EMIT;
                    endcase
                end
            end
            S_READ: state_next = S_ORG;
            S_ORG:  state_next = cell_mode_reg ? S_NUM : S_ADD;
            S_NUM:  state_next = S_DIV;
            S_DIV:  state_next = S_ADD;
            S_ADD:  state_next = axis_reg ? S_EMIT : S_ORG;
            S_EMIT:
            begin
                if (emit_fire)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // scan state and datapath
    always_comb
    begin
        phase_next     = phase_reg;
        chk_col_next   = chk_col_reg;
        chk_row_next   = chk_row_reg;
        count_next     = count_reg;
        cell_col_next  = cell_col_reg;
        cell_row_next  = cell_row_reg;
        axis_next      = axis_reg;
        cell_mode_next = cell_mode_reg;
        pv_next        = pv_reg;
        wrong_next     = wrong_reg;
        done_next      = done_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        kx_next        = kx_reg;
        ky_next        = ky_reg;
        acc_x_next     = acc_x_reg;
        acc_y_next     = acc_y_reg;
        num_next       = num_reg;
        quo_next       = quo_reg;
        push           = 1'b0;
        pop            = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_accept)
                begin
                    axis_next      = 1'b0;
                    cell_mode_next = 1'b0;
                    pv_next        = 1'b1;
                    wrong_next     = 1'b0;
                    done_next      = 1'b0;
                    unique case (act)
                        ACT_RESTART:
                        begin
                            phase_next    = PH_CHECK;
                            chk_col_next  = '0;
                            chk_row_next  = '0;
                            count_next    = '0;
                            cell_col_next = '0;
                            cell_row_next = '0;
                            px_next       = pack_x('0, '0);
                            py_next       = pack_y('0);
                        end
                        ACT_REPORT:
                        begin
                            if (check_passed && count_reg < CNT_W'(PACK_TOTAL))
                            begin
                                push       = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                            if (chk_last)
                            begin
                                phase_next    = (count_reg != '0 || push) ? PH_TARGET : PH_DONE;
                                cell_col_next = '0;
                                cell_row_next = '0;
                                pv_next       = 1'b0;
                            end
                            else
                            begin
                                chk_col_next = nxt_col;
                                chk_row_next = nxt_row;
                                px_next      = pack_x(nxt_row, nxt_col);
                                py_next      = pack_y(nxt_row);
                            end
                        end
                        ACT_TARGET:
                        begin
                            pop            = 1'b1;
                            cell_mode_next = 1'b1;
                            // odd cell rows run right to left
                            if (cell_row_reg[0])
                                kx_next = K_W'(CC_W'(CELL_COLUMNS - 1) - cell_col_reg);
                            else
                                kx_next = K_W'(cell_col_reg);
                            ky_next = K_W'(cell_row_reg);
                            if (cell_col_last)
                            begin
                                cell_col_next = '0;
                                if (cell_row_last)
                                begin
                                    cell_row_next = '0;
                                    done_next     = 1'b1;
                                    count_next    = cnt_dec;
                                    if (cnt_dec == '0)
                                        phase_next = PH_DONE;
                                end
                                else
                                begin
                                    cell_row_next = cell_row_reg + CR_W'(1);
                                end
                            end
                            else
                            begin
                                cell_col_next = cell_col_reg + CC_W'(1);
                            end
                        end
                        ACT_WRONG:
                        begin
                            wrong_next = 1'b1;
                            pv_next    = 1'b0;
                        end
                        default:
                        begin
                            wrong_next = 1'b1;
                            pv_next    = 1'b0;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                px_next = rd_slot_reg[PX_W-1:0];
                py_next = rd_slot_reg[SLOT_W-1:PX_W];
            end
            S_ORG:
            begin
                if (axis_reg)
                    acc_y_next = mac_res;
                else
                    acc_x_next = mac_res;
            end
            S_NUM:
            begin
                num_next = mac_res[NUM_W-1:0];
            end
            S_DIV:
            begin
                // the rounded offset never exceeds the pack length
                quo_next = mac_prod[RECIP_SH +: LEN_W];
            end
            S_ADD:
            begin
                if (axis_reg)
                begin
                    acc_y_next = mac_res;
                end
                else
                begin
                    acc_x_next = mac_res;
                    axis_next  = 1'b1;
                end
            end
            S_EMIT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    assign result_valid_next = (result_valid_reg && result_stall) || emit_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_margin_reg   <= '0;
            bottom_margin_reg <= '0;
            pack_width_reg    <= '0;
            pack_height_reg   <= '0;
            gap_x_reg         <= '0;
            gap_y_reg         <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_LEFT_MARGIN:   left_margin_reg   <= cfg_data[MARGIN_W-1:0];
                CFG_BOTTOM_MARGIN: bottom_margin_reg <= cfg_data[MARGIN_W-1:0];
                CFG_PACK_WIDTH:    pack_width_reg    <= cfg_data[LEN_W-1:0];
                CFG_PACK_HEIGHT:   pack_height_reg   <= cfg_data[LEN_W-1:0];
                CFG_GAP_X:         gap_x_reg         <= cfg_data[LEN_W-1:0];
                CFG_GAP_Y:         gap_y_reg         <= cfg_data[LEN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            phase_reg        <= PH_CHECK;
            chk_col_reg      <= '0;
            chk_row_reg      <= '0;
            count_reg        <= '0;
            cell_col_reg     <= '0;
            cell_row_reg     <= '0;
            axis_reg         <= 1'b0;
            cell_mode_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            phase_reg        <= phase_next;
            chk_col_reg      <= chk_col_next;
            chk_row_reg      <= chk_row_next;
            count_reg        <= count_next;
            cell_col_reg     <= cell_col_next;
            cell_row_reg     <= cell_row_next;
            axis_reg         <= axis_next;
            cell_mode_reg    <= cell_mode_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pv_reg    <= pv_next;
        wrong_reg <= wrong_next;
        done_reg  <= done_next;
        px_reg    <= px_next;
        py_reg    <= py_next;
        kx_reg    <= kx_next;
        ky_reg    <= ky_next;
        acc_x_reg <= acc_x_next;
        acc_y_reg <= acc_y_next;
        num_reg   <= num_next;
        quo_reg   <= quo_next;
        if (emit_fire)
        begin
            phase_out_reg   <= phase_reg;
            point_valid_reg <= pv_reg;
            point_x_reg     <= pv_reg ? acc_x_reg : '0;
            point_y_reg     <= pv_reg ? acc_y_reg : '0;
            pack_done_reg   <= done_reg;
            wrong_phase_reg <= wrong_reg;
        end
    end

    // passed-pack stack, one write or one registered read per transfer
    always_ff @(posedge clk)
    begin
        if (push)
            stack_mem[wr_addr] <= cur_slot;
        if (pop)
            rd_slot_reg <= stack_mem[rd_addr];
    end

`ifndef ASSERT_OFF
    a_done_has_point: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && pack_done) |-> (point_valid && phase != PH_CHECK))
        else $error("pack_done without a target point");

    a_wrong_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && wrong_phase) |-> (!point_valid && !pack_done))
        else $error("wrong_phase result carries a point");

    a_target_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_TARGET) |-> (count_reg != '0))
        else $error("target phase with an empty pack stack");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item_accept |=> (item_stall && !$stable(state_reg)))
        else $error("sequencer did not start after a transfer");
`endif

endmodule

// File: sim/testbench.sv
// self-checking testbench for the serpentine grid scan point generator core
`timescale 1ns / 100ps

module testbench;
    import spg_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned SETTLE_CYCLES = 60;
    localparam int unsigned SEGMENT_ITEMS = 150;
    localparam int unsigned NO_CAP = 32'h7fffffff;

    // register setting styles
    localparam int CFG_ZERO = 0;
    localparam int CFG_MAX = 1;
    localparam int CFG_RANDOM = 2;
    localparam int CFG_SMALL = 3;

    localparam logic [CFG_IDX_W-1:0] REG_ORDER [6] = '{CFG_LEFT_MARGIN, CFG_BOTTOM_MARGIN,
        CFG_PACK_WIDTH, CFG_PACK_HEIGHT, CFG_GAP_X, CFG_GAP_Y};

    typedef struct packed {
        logic [1:0]         phase;
        logic               point_valid;
        logic [COORD_W-1:0] point_x;
        logic [COORD_W-1:0] point_y;
        logic               pack_done;
        logic               wrong_phase;
    } scan_result_t;

    class scan_scoreboard;
        bit [MARGIN_W-1:0] left_margin, bottom_margin;
        bit [LEN_W-1:0]    pack_width, pack_height, gap_x, gap_y;
        phase_t            scan_phase;
        int unsigned       check_pos, passed_count, cell_row, cell_col;
        bit [IDX_W-1:0]    passed_stack [PACK_TOTAL];
        scan_result_t      expected_points [$];
        int unsigned       errors, checked;

        function new();
            left_margin = 0;
            bottom_margin = 0;
            pack_width = 0;
            pack_height = 0;
            gap_x = 0;
            gap_y = 0;
            errors = 0;
            checked = 0;
            clear_scan();
        endfunction

        function void clear_scan();
            scan_phase = PH_CHECK;
            check_pos = 0;
            passed_count = 0;
            cell_row = 0;
            cell_col = 0;
            foreach (passed_stack[i])
                passed_stack[i] = '0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_LEFT_MARGIN:   left_margin = data;
                CFG_BOTTOM_MARGIN: bottom_margin = data;
                CFG_PACK_WIDTH:    pack_width = data[LEN_W-1:0];
                CFG_PACK_HEIGHT:   pack_height = data[LEN_W-1:0];
                CFG_GAP_X:         gap_x = data[LEN_W-1:0];
                CFG_GAP_Y:         gap_y = data[LEN_W-1:0];
                default:           ;
            endcase
        endfunction

        // serpentine position to pack column / row: top row first, right to left
        function int unsigned pos_x(int unsigned pos);
            int unsigned m;
            m = pos / PACK_COLUMNS;
            return (m % 2) ? pos % PACK_COLUMNS : PACK_COLUMNS - 1 - pos % PACK_COLUMNS;
        endfunction

        function int unsigned pos_y(int unsigned pos);
            return PACK_ROWS - 1 - pos / PACK_COLUMNS;
        endfunction

        function bit [31:0] origin_x(int unsigned px);
            return left_margin + px * (pack_width + gap_x);
        endfunction

        function bit [31:0] origin_y(int unsigned py);
            return bottom_margin + py * (pack_height + gap_y);
        endfunction

        // len*k/div rounded half up, exact
        function int unsigned round_share(int unsigned len, int unsigned k, int unsigned div);
            return (2 * len * k + div) / (2 * div);
        endfunction

        function scan_result_t check_point();
            scan_result_t r;
            bit [31:0] sum_x, sum_y;
            r = '0;
            sum_x = origin_x(pos_x(check_pos)) + pack_width / 2;
            sum_y = origin_y(pos_y(check_pos)) + pack_height / 2;
            r.point_valid = 1'b1;
            r.point_x = sum_x[COORD_W-1:0];
            r.point_y = sum_y[COORD_W-1:0];
            return r;
        endfunction

        function scan_result_t predict_point(logic [KIND_W-1:0] kind_v, logic passed);
            scan_result_t r;
            int unsigned idx, px, py, col;
            bit [31:0] sum_x, sum_y;
            r = '0;
            if (kind_v == KIND_RESTART) begin
                clear_scan();
                r = check_point();
            end else if (kind_v == KIND_REPORT && scan_phase == PH_CHECK) begin
                if (passed && passed_count < PACK_TOTAL) begin
                    passed_stack[passed_count] =
                        IDX_W'(pos_x(check_pos) + pos_y(check_pos) * PACK_COLUMNS);
                    passed_count++;
                end
                check_pos++;
                if (check_pos < PACK_TOTAL) begin
                    r = check_point();
                end else begin
                    scan_phase = (passed_count != 0) ? PH_TARGET : PH_DONE;
                    cell_row = 0;
                    cell_col = 0;
                end
            end else if (kind_v == KIND_TARGET && scan_phase == PH_TARGET && passed_count > 0)
            begin
                idx = passed_stack[passed_count - 1];
                px = idx % PACK_COLUMNS;
                py = (idx / PACK_COLUMNS) % PACK_ROWS;
                // odd cell rows run right to left
                col = (cell_row % 2) ? CELL_COLUMNS - 1 - cell_col : cell_col;
                sum_x = origin_x(px) + round_share(pack_width, col, CELL_COLUMNS - 1);
                sum_y = origin_y(py) + round_share(pack_height, cell_row, CELL_ROWS - 1);
                r.point_valid = 1'b1;
                r.point_x = sum_x[COORD_W-1:0];
                r.point_y = sum_y[COORD_W-1:0];
                cell_col++;
                if (cell_col >= CELL_COLUMNS) begin
                    cell_col = 0;
                    cell_row++;
                    if (cell_row >= CELL_ROWS) begin
                        cell_row = 0;
                        r.pack_done = 1'b1;
                        passed_count--;
                        if (passed_count == 0)
                            scan_phase = PH_DONE;
                    end
                end
            end else begin
                r.wrong_phase = 1'b1;
            end
            r.phase = scan_phase;
            return r;
        endfunction

        // returns 1 when the item was out of phase and ignored
        function bit note_item(logic [KIND_W-1:0] kind_v, logic passed);
            scan_result_t r;
            r = predict_point(kind_v, passed);
            expected_points.push_back(r);
            return r.wrong_phase;
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40)
                $display("MISMATCH: %s", msg);
        endtask

        task compare_field(string name, int unsigned got, int unsigned want);
            if (got != want)
                report($sformatf("result %0d %s: got %0d expected %0d",
                                 checked, name, got, want));
        endtask

        task check_result(scan_result_t got);
            scan_result_t want;
            if (expected_points.size() == 0) begin
                report("result transfer with no item pending");
                return;
            end
            want = expected_points.pop_front();
            compare_field("phase", got.phase, want.phase);
            compare_field("point_valid", got.point_valid, want.point_valid);
            compare_field("point_x", got.point_x, want.point_x);
            compare_field("point_y", got.point_y, want.point_y);
            compare_field("pack_done", got.pack_done, want.pack_done);
            compare_field("wrong_phase", got.wrong_phase, want.wrong_phase);
            checked++;
        endtask
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 item_valid;
    logic                 item_stall;
    logic [KIND_W-1:0]    kind;
    logic                 check_passed;
    logic                 result_valid;
    logic                 result_stall;
    logic [1:0]           phase;
    logic                 point_valid;
    logic [COORD_W-1:0]   point_x;
    logic [COORD_W-1:0]   point_y;
    logic                 pack_done;
    logic                 wrong_phase;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    scan_scoreboard sb;
    int unsigned cycle_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned useful_items = 0;
    int unsigned scans_run = 0;
    int unsigned settings_run = 0;

    serpentine_grid_scan_point_generator_core DUT (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver: random stall, check every result transfer
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_result({phase, point_valid, point_x, point_y, pack_done, wrong_phase});
        result_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    task automatic send_item(input logic [KIND_W-1:0] k, input logic p);
        while ($urandom_range(99) < send_idle_pct) begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        kind <= k;
        check_passed <= p;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        if (!sb.note_item(k, p))
            useful_items++;
    endtask

    task automatic drain_results();
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_points.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(input int style);
        logic [CFG_W-1:0] top, v;
        for (int i = 0; i < 6; i++) begin
            top = (REG_ORDER[i] == CFG_LEFT_MARGIN || REG_ORDER[i] == CFG_BOTTOM_MARGIN)
                  ? 16'hffff : 16'h3fff;
            case (style)
                CFG_ZERO:   v = '0;
                CFG_MAX:    v = top;
                CFG_SMALL:  v = $urandom_range(40);
                default:    v = $urandom_range(top);
            endcase
            cfg_write <= 1'b1;
            cfg_index <= REG_ORDER[i];
            cfg_data <= v;
            @(posedge clk);
            sb.set_reg(REG_ORDER[i], v);
        end
        cfg_write <= 1'b0;
        settings_run++;
    endtask

    // out-of-phase or unused kinds sprinkled into the flow
    task automatic maybe_noise();
        logic [KIND_W-1:0] k;
        if ($urandom_range(99) < 6) begin
            if ($urandom_range(1))
                k = KIND_UNUSED;
            else
                k = (sb.scan_phase == PH_CHECK) ? KIND_TARGET : KIND_REPORT;
            send_item(k, $urandom_range(1));
        end
    endtask

    // one restart, a full check pass, then targets until done or the cap
    task automatic run_scan(input int unsigned keep_odds, input int unsigned target_cap);
        int unsigned served;
        send_item(KIND_RESTART, $urandom_range(1));
        while (sb.scan_phase == PH_CHECK) begin
            maybe_noise();
            if ($urandom_range(199) == 0)
                send_item(KIND_RESTART, $urandom_range(1));
            else
                send_item(KIND_REPORT, $urandom_range(63) < keep_odds);
        end
        served = 0;
        while (sb.scan_phase == PH_TARGET && served < target_cap) begin
            maybe_noise();
            send_item(KIND_TARGET, $urandom_range(1));
            served++;
        end
        repeat ($urandom_range(2))
            send_item($urandom_range(1, 3), $urandom_range(1));
        scans_run++;
    endtask

    initial
    begin
        int unsigned seg_start, cap;
        int styles [6];
        sb = new();
        rst_n = 1'b0;
        item_valid = 1'b0;
        kind = KIND_RESTART;
        check_passed = 1'b0;
        result_stall = 1'b0;
        cfg_write = 1'b0;
        cfg_index = CFG_LEFT_MARGIN;
        cfg_data = '0;
        styles = '{CFG_RANDOM, CFG_MAX, CFG_SMALL, CFG_ZERO, CFG_RANDOM, CFG_SMALL};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: every kind in the check phase, maximum register values
        write_config(CFG_MAX);
        send_item(KIND_TARGET, 1'b1);
        send_item(KIND_UNUSED, 1'b1);
        send_item(KIND_REPORT, 1'b1);
        send_item(KIND_REPORT, 1'b0);
        send_item(KIND_UNUSED, 1'b0);
        send_item(KIND_RESTART, 1'b1);
        send_item(KIND_TARGET, 1'b0);
        send_item(KIND_REPORT, 1'b1);
        send_item(KIND_RESTART, 1'b0);
        drain_results();

        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct = (mode == 0) ? 22 : (mode == 1) ? 77 : 0;
            recv_idle_pct = (mode == 0) ? 77 : (mode == 1) ? 22 : 0;
            for (int s = 0; s < 2; s++) begin
                write_config(styles[mode * 2 + s]);
                seg_start = useful_items;
                // every pack passes once: deepest stack, popped part way then restarted
                if (mode == 2 && s == 1)
                    run_scan(64, 130);
                while (useful_items - seg_start < SEGMENT_ITEMS) begin
                    cap = ($urandom_range(7) == 0) ? $urandom_range(1, 100) : NO_CAP;
                    run_scan($urandom_range(3), cap);
                end
                drain_results();
            end
        end

        if (sb.expected_points.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.expected_points.size()));
        $display("run covered %0d scans over %0d register settings and three idle mixes",
                 scans_run, settings_run);
        $display("%0d results checked, %0d in-phase items, %0d mismatches",
                 sb.checked, useful_items, sb.errors);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
